/* sv/vfs_pkg.sv */
package vfs_pkg;

  localparam int SCREEN_BITS_DEF = 14;
  localparam int GAME_BITS_DEF   = 13;
  localparam int SRC_BITS        = 16;
  localparam int SRC_MAX         = 65535;
  localparam int GAME_RESET      = 64;
  localparam int ADDR_BITS       = 2;
  localparam int MODE_BITS       = 3;

  localparam logic [ADDR_BITS-1:0] REG_GAME_WIDTH  = 2'd0;
  localparam logic [ADDR_BITS-1:0] REG_GAME_HEIGHT = 2'd1;
  localparam logic [ADDR_BITS-1:0] REG_FIT_MODE    = 2'd2;

  localparam logic [MODE_BITS-1:0] MODE_INTEGER    = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_HEIGHT     = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_WIDTH      = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_ASPECT     = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_HEIGHT_ALT = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_WIDTH_ALT  = 3'd5;

endpackage

/* sv/vfs_cfg_if.sv */
interface vfs_cfg_if #(
  parameter int GB = vfs_pkg::GAME_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [vfs_pkg::ADDR_BITS-1:0]  addr;
  logic [GB-1:0]                  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

/* sv/vfs_in_if.sv */
interface vfs_in_if #(
  parameter int SB = vfs_pkg::SCREEN_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [SB-1:0] screen_width;
  logic [SB-1:0] screen_height;

  modport source (output valid, output screen_width, output screen_height, input ready);
  modport sink (input valid, input screen_width, input screen_height, output ready);
endinterface

/* sv/vfs_out_if.sv */
interface vfs_out_if #(
  parameter int SB = vfs_pkg::SCREEN_BITS_DEF,
  parameter int GB = vfs_pkg::GAME_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [GB-1:0]                source_y;
  logic [vfs_pkg::SRC_BITS-1:0] source_width;
  logic [vfs_pkg::SRC_BITS-1:0] source_height;
  logic [SB-1:0]                dest_x;
  logic [SB-1:0]                dest_y;
  logic [SB-1:0]                dest_width;
  logic [SB-1:0]                dest_height;

  modport source (output valid, output source_y, output source_width, output source_height,
                  output dest_x, output dest_y, output dest_width, output dest_height,
                  input ready);
  modport sink (input valid, input source_y, input source_width, input source_height,
                input dest_x, input dest_y, input dest_width, input dest_height,
                output ready);
endinterface

/* sv/vfs_cfg.sv */
module vfs_cfg #(
  parameter int GB = vfs_pkg::GAME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  vfs_cfg_if.sink                       cfg_chan,
  output logic [GB-1:0]                 game_width,
  output logic [GB-1:0]                 game_height,
  output logic [vfs_pkg::MODE_BITS-1:0] fit_mode
);
  import vfs_pkg::*;

  logic [GB-1:0]        gw_r;
  logic [GB-1:0]        gh_r;
  logic [MODE_BITS-1:0] mode_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r   <= GB'(GAME_RESET);
      gh_r   <= GB'(GAME_RESET);
      mode_r <= MODE_INTEGER;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.addr)
        REG_GAME_WIDTH:  gw_r <= cfg_chan.data;
        REG_GAME_HEIGHT: gh_r <= cfg_chan.data;
        REG_FIT_MODE:    mode_r <= cfg_chan.data[MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign game_width  = gw_r;
  assign game_height = gh_r;
  assign fit_mode    = mode_r;
endmodule

/* sv/vfs_div.sv */
module vfs_div #(
  parameter int NW = 27,
  parameter int DW = 14,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_vld,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [TW-1:0] tag_out
);
  logic [NW-1:0] vld_r;
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] den_r [NW];
  logic [TW-1:0] tag_r [NW];

  logic [NW-1:0] vld_p;
  logic [DW-1:0] rem_p [NW];
  logic [NW-1:0] nq_p  [NW];
  logic [DW-1:0] den_p [NW];
  logic [TW-1:0] tag_p [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] nq_nxt;

    if (s == 0) begin : g_first
      assign vld_p[s] = in_vld;
      assign rem_p[s] = '0;
      assign nq_p[s]  = num;
      assign den_p[s] = den;
      assign tag_p[s] = tag;
    end else begin : g_next
      assign vld_p[s] = vld_r[s-1];
      assign rem_p[s] = rem_r[s-1];
      assign nq_p[s]  = nq_r[s-1];
      assign den_p[s] = den_r[s-1];
      assign tag_p[s] = tag_r[s-1];
    end

    assign trial   = {rem_p[s], nq_p[s][NW-1]};
    assign ge      = trial >= {1'b0, den_p[s]};
    assign diff    = trial - {1'b0, den_p[s]};
    assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign nq_nxt  = {nq_p[s][NW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_p[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        nq_r[s]  <= nq_nxt;
        den_r[s] <= den_p[s];
        tag_r[s] <= tag_p[s];
      end
    end
  end

  assign out_vld = vld_r[NW-1];
  assign quo     = nq_r[NW-1];
  assign rem     = rem_r[NW-1];
  assign tag_out = tag_r[NW-1];
endmodule

/* sv/viewport_fit_scaler.sv */
// Letterbox viewport fit. The cfg_chan port writes game_width, game_height and
// fit_mode; its ready is always high and a write lands at the handshake edge.
// Each in_chan transaction carries a window size and yields exactly one
// out_chan transaction with the source and centered destination rectangles.
// Transactions are returned in order.
// Each result passes an input product stage, a first division (two bit-serial
// dividers side by side), a mid stage, a second bit-serial divider and the
// output register; each divider yields one quotient bit per stage.
// Throughput is one transaction per cycle while out_chan is not stalled.
// When out_chan is stalled with a result held in the output register, the
// whole pipeline holds and in_chan ready drops; no data is lost or repeated.
// Synchronous reset clears all valid bits, so the pipeline empties, and sets
// the registers to a 64 by 64 game frame in whole-number scale mode.
// Configuration must only be written while no transaction is in flight.
module viewport_fit_scaler #(
  parameter int SCREEN_BITS = vfs_pkg::SCREEN_BITS_DEF,
  parameter int GAME_BITS   = vfs_pkg::GAME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vfs_cfg_if.sink   cfg_chan,
  vfs_in_if.sink    in_chan,
  vfs_out_if.source out_chan
);
  import vfs_pkg::*;

  localparam int SB = SCREEN_BITS;
  localparam int GB = GAME_BITS;
  localparam int PW = SB + GB;
  localparam int DW = (SB > GB) ? SB : GB;

  typedef struct packed {
    logic [SB-1:0]        sw;
    logic [SB-1:0]        sh;
    logic [GB-1:0]        gw;
    logic [GB-1:0]        gh;
    logic [MODE_BITS-1:0] mode;
  } item_t;

  typedef struct packed {
    item_t         it;
    logic [SB-1:0] dw;
    logic [SB-1:0] dh;
    logic [SB-1:0] dx;
    logic [SB-1:0] dy;
    logic [PW-1:0] src;
  } mid_t;

  logic [GB-1:0]        cfg_gw;
  logic [GB-1:0]        cfg_gh;
  logic [MODE_BITS-1:0] cfg_mode;
  logic                 en;

  vfs_cfg #(.GB(GB)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_chan    (cfg_chan),
    .game_width  (cfg_gw),
    .game_height (cfg_gh),
    .fit_mode    (cfg_mode)
  );

  // Input stage: cross products.
  logic          s1_vld_r;
  item_t         s1_it_r;
  logic [PW-1:0] s1_pw_r;
  logic [PW-1:0] s1_ph_r;

  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_it_r <= '{sw: in_chan.screen_width, sh: in_chan.screen_height,
                   gw: cfg_gw, gh: cfg_gh, mode: cfg_mode};
      s1_pw_r <= PW'(in_chan.screen_width) * PW'(cfg_gh);
      s1_ph_r <= PW'(in_chan.screen_height) * PW'(cfg_gw);
    end
  end

  // Operand selection for the first division.
  logic          wide;
  logic [PW-1:0] x_num;
  logic [DW-1:0] x_den;
  logic [PW-1:0] y_num;
  logic [DW-1:0] y_den;

  assign wide = s1_pw_r <= s1_ph_r;

  always_comb begin
    x_num = '0;
    x_den = '0;
    y_num = PW'(s1_it_r.sh);
    y_den = DW'(s1_it_r.gh);
    case (s1_it_r.mode)
      MODE_INTEGER: begin
        x_num = PW'(s1_it_r.sw);
        x_den = DW'(s1_it_r.gw);
      end
      MODE_ASPECT: begin
        x_num = wide ? s1_pw_r : s1_ph_r;
        x_den = wide ? DW'(s1_it_r.gw) : DW'(s1_it_r.gh);
      end
      MODE_HEIGHT, MODE_HEIGHT_ALT: begin
        x_num = s1_pw_r;
        x_den = DW'(s1_it_r.sh);
      end
      MODE_WIDTH, MODE_WIDTH_ALT: begin
        x_num = s1_ph_r;
        x_den = DW'(s1_it_r.sw);
      end
      default: ;
    endcase
  end

  logic          x_vld;
  logic [PW-1:0] x_quo;
  logic [DW-1:0] x_rem;
  item_t         x_it;
  logic          y_vld;
  logic [PW-1:0] y_quo;
  logic [DW-1:0] y_rem;
  logic          y_wide;

  vfs_div #(.NW(PW), .DW(DW), .TW($bits(item_t))) u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s1_vld_r),
    .num     (x_num),
    .den     (x_den),
    .tag     (s1_it_r),
    .out_vld (x_vld),
    .quo     (x_quo),
    .rem     (x_rem),
    .tag_out (x_it)
  );

  vfs_div #(.NW(PW), .DW(DW), .TW(1)) u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s1_vld_r),
    .num     (y_num),
    .den     (y_den),
    .tag     (wide),
    .out_vld (y_vld),
    .quo     (y_quo),
    .rem     (y_rem),
    .tag_out (y_wide)
  );

  // Mid stage: scale products and the fractional-aspect results.
  logic [SB-1:0] k;
  logic [PW-1:0] kw_prod;
  logic [PW-1:0] kh_prod;
  logic [SB-1:0] q3;
  logic [SB:0]   ceil3;
  logic [SB:0]   slack3;
  mid_t          mid_nxt;
  logic [DW-1:0] r1_nxt;

  assign k       = (x_quo[SB-1:0] < y_quo[SB-1:0]) ? x_quo[SB-1:0] : y_quo[SB-1:0];
  assign kw_prod = PW'(k) * PW'(x_it.gw);
  assign kh_prod = PW'(k) * PW'(x_it.gh);
  assign q3      = x_quo[SB-1:0];
  assign ceil3   = (SB+1)'(q3) + (SB+1)'(x_rem != '0 || y_rem == '1 && 1'b0);
  assign slack3  = y_wide ? ((SB+1)'(x_it.sh) - ceil3) : ((SB+1)'(x_it.sw) - ceil3);

  always_comb begin
    mid_nxt    = '0;
    mid_nxt.it = x_it;
    mid_nxt.src = x_quo;
    r1_nxt     = x_rem;
    case (x_it.mode)
      MODE_INTEGER: begin
        mid_nxt.dw = kw_prod[SB-1:0];
        mid_nxt.dh = kh_prod[SB-1:0];
      end
      MODE_ASPECT: begin
        if (y_wide) begin
          mid_nxt.dw = x_it.sw;
          mid_nxt.dh = q3;
          mid_nxt.dy = slack3[SB:1];
        end else begin
          mid_nxt.dh = x_it.sh;
          mid_nxt.dw = q3;
          mid_nxt.dx = slack3[SB:1];
        end
      end
      default: ;
    endcase
  end

  logic          m_vld_r;
  mid_t          m_r;
  logic [DW-1:0] m_r1_r;
  logic [DW-1:0] z_den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= x_vld & y_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= mid_nxt;
      m_r1_r <= r1_nxt;
    end
  end

  assign z_den = (m_r.it.mode == MODE_HEIGHT || m_r.it.mode == MODE_HEIGHT_ALT) ?
                 DW'(m_r.it.gh) : DW'(m_r.it.gw);

  logic          z_vld;
  logic [DW-1:0] z_quo;
  logic [DW-1:0] z_rem;
  mid_t          z_m;

  vfs_div #(.NW(DW), .DW(DW), .TW($bits(mid_t))) u_div_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (m_vld_r),
    .num     (m_r1_r),
    .den     (z_den),
    .tag     (m_r),
    .out_vld (z_vld),
    .quo     (z_quo),
    .rem     (z_rem),
    .tag_out (z_m)
  );

  // Final assembly.
  logic [DW:0]     ceil_z;
  logic [SB-1:0]   half_z;
  logic [32:0]     src_ext;
  logic [SRC_BITS-1:0] src_sat;
  logic [SB:0]     sw_ext;
  logic [SB:0]     sh_ext;
  logic [DW:0]     sw_dif;
  logic [DW:0]     sh_dif;
  logic [GB-1:0]   sy_nxt;
  logic [SRC_BITS-1:0] srw_nxt;
  logic [SRC_BITS-1:0] srh_nxt;
  logic [SB-1:0]   dx_nxt;
  logic [SB-1:0]   dy_nxt;
  logic [SB-1:0]   dw_nxt;
  logic [SB-1:0]   dh_nxt;

  assign ceil_z  = (DW+1)'(z_quo) + (DW+1)'(z_rem != '0);
  assign half_z  = SB'(z_quo >> 1);
  assign src_ext = 33'(z_m.src);
  assign src_sat = (src_ext > 33'(SRC_MAX)) ? SRC_BITS'(SRC_MAX) : src_ext[SRC_BITS-1:0];
  assign sw_ext  = (SB+1)'(z_m.it.sw);
  assign sh_ext  = (SB+1)'(z_m.it.sh);
  assign sw_dif  = (DW+1)'(z_m.it.sw) - ceil_z;
  assign sh_dif  = (DW+1)'(z_m.it.sh) - ceil_z;

  always_comb begin
    sy_nxt  = '0;
    srw_nxt = '0;
    srh_nxt = '0;
    dx_nxt  = '0;
    dy_nxt  = '0;
    dw_nxt  = '0;
    dh_nxt  = '0;
    if (z_m.it.gw != '0 && z_m.it.gh != '0) begin
      case (z_m.it.mode)
        MODE_INTEGER: begin
          sy_nxt  = z_m.it.gh;
          srw_nxt = SRC_BITS'(z_m.it.gw);
          srh_nxt = SRC_BITS'(z_m.it.gh);
          dw_nxt  = z_m.dw;
          dh_nxt  = z_m.dh;
          dx_nxt  = SB'((sw_ext - (SB+1)'(z_m.dw)) >> 1);
          dy_nxt  = SB'((sh_ext - (SB+1)'(z_m.dh)) >> 1);
        end
        MODE_ASPECT: begin
          sy_nxt  = z_m.it.gh;
          srw_nxt = SRC_BITS'(z_m.it.gw);
          srh_nxt = SRC_BITS'(z_m.it.gh);
          dw_nxt  = z_m.dw;
          dh_nxt  = z_m.dh;
          dx_nxt  = z_m.dx;
          dy_nxt  = z_m.dy;
        end
        MODE_HEIGHT, MODE_HEIGHT_ALT: begin
          srh_nxt = SRC_BITS'(z_m.it.gh);
          if (z_m.it.sh == '0) begin
            srw_nxt = SRC_BITS'(SRC_MAX);
            dx_nxt  = z_m.it.sw >> 1;
          end else begin
            srw_nxt = src_sat;
            dw_nxt  = sw_dif[SB-1:0];
            dh_nxt  = z_m.it.sh;
            dx_nxt  = half_z;
          end
        end
        MODE_WIDTH, MODE_WIDTH_ALT: begin
          srw_nxt = SRC_BITS'(z_m.it.gw);
          if (z_m.it.sw == '0) begin
            srh_nxt = SRC_BITS'(SRC_MAX);
            dy_nxt  = z_m.it.sh >> 1;
          end else begin
            srh_nxt = src_sat;
            dh_nxt  = sh_dif[SB-1:0];
            dw_nxt  = z_m.it.sw;
            dy_nxt  = half_z;
          end
        end
        default: ;
      endcase
    end
  end

  logic                out_vld_r;
  logic [GB-1:0]       sy_r;
  logic [SRC_BITS-1:0] srw_r;
  logic [SRC_BITS-1:0] srh_r;
  logic [SB-1:0]       dx_r;
  logic [SB-1:0]       dy_r;
  logic [SB-1:0]       dw_r;
  logic [SB-1:0]       dh_r;

  assign en = !out_vld_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= z_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sy_r  <= sy_nxt;
      srw_r <= srw_nxt;
      srh_r <= srh_nxt;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      dw_r  <= dw_nxt;
      dh_r  <= dh_nxt;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.source_y      = sy_r;
  assign out_chan.source_width  = srw_r;
  assign out_chan.source_height = srh_r;
  assign out_chan.dest_x        = dx_r;
  assign out_chan.dest_y        = dy_r;
  assign out_chan.dest_width    = dw_r;
  assign out_chan.dest_height   = dh_r;
endmodule
